// ----- rtl/gbad_pkg.sv -----
// shared types, register map and constants of the gnss binary/ascii deframer
package gbad_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  localparam int unsigned MIN_CAP          = 9;
  localparam logic [7:0]  ASCII_MARK       = 8'h24;
  localparam int unsigned MIN_VALID_BYTES  = 8;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] REG_START_CHAR  = 3'd2;
  localparam logic [2:0] REG_END_FIRST   = 3'd3;
  localparam logic [2:0] REG_END_SECOND  = 3'd4;
  localparam logic [2:0] REG_ABORT_CHAR  = 3'd5;
  localparam logic [2:0] REG_MAX_BYTES   = 3'd6;
  localparam logic [2:0] REG_BIG_ENDIAN  = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_TXT  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_SYNC2 = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LEN2  = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IGNORED     = 3'd0,
    ST_IN_FRAME    = 3'd1,
    ST_VALID_END   = 3'd2,
    ST_INVALID_END = 3'd3,
    ST_ABORTED     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_BINARY = 2'd1,
    KIND_ASCII  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  start_char;
    logic [7:0]  end_first;
    logic [7:0]  end_second;
    logic [7:0]  abort_char;
    logic [12:0] max_frame_bytes;
    logic        big_endian;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    phase_e      phase;
    logic        cr_seen;
    logic [7:0]  held_id;
    logic [15:0] held_len;
    logic [16:0] left;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic        chk_ok;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    mode:     MODE_IDLE,
    phase:    PH_SYNC2,
    cr_seen:  1'b0,
    held_id:  8'h00,
    held_len: 16'h0000,
    left:     17'h00000,
    sum_a:    8'h00,
    sum_b:    8'h00,
    chk_ok:   1'b0
  };

  typedef struct packed {
    logic [7:0]  byte_echo;
    status_e     status;
    kind_e       kind;
    logic        drop;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic [31:0] stream_index;
  } result_t;

endpackage

// ----- rtl/gnss_binary_ascii_deframer.sv -----
// top level of the gnss binary/ascii deframer
//
// channel   | dir | word contents (lsb first)
// s_axis    | in  | tdata: rx_byte[7:0]
// m_axis    | out | tdata: byte_echo, message_id, payload_length, stream_index
//           |     | tuser: frame_status, frame_kind, overflow_drop
// apb       | in  | eight 32-bit registers at byte address 4*index
//
// one word in, one word out; a word is accepted every cycle while the output is not stalled
// each word passes the input register, the tracker update and the output register
// the tracker state is a single register set updated once per word
// reset clears all tracking state and loads the register defaults
// a stalled output keeps the input register full and then s_axis_tready falls
module gnss_binary_ascii_deframer #(
  parameter int unsigned BUFFER_BYTES = gbad_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // byte_echo[7:0], message_id[15:8],
                                      // payload_length[31:16], stream_index[63:32]
  output logic [7:0]  m_axis_tuser,   // frame_status[2:0], frame_kind[4:3],
                                      // overflow_drop[5], zero[7:6]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gbad_pkg::*;

  cfg_t       cfg;
  result_t    res;
  result_t    out_q;
  logic       out_valid_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       adv;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || adv;

  gbad_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gbad_frame_tracker #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.stream_index, out_q.payload_length,
                          out_q.message_id, out_q.byte_echo};
  assign m_axis_tuser  = {2'b00, out_q.drop, out_q.kind, out_q.status};

endmodule

// ----- rtl/gbad_apb_regs.sv -----
// apb configuration registers of the deframer
module gbad_apb_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output gbad_pkg::cfg_t       cfg_o
);
  import gbad_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first      <= 8'd69;
      cfg_q.sync_second     <= 8'd82;
      cfg_q.start_char      <= 8'd36;
      cfg_q.end_first       <= 8'd13;
      cfg_q.end_second      <= 8'd10;
      cfg_q.abort_char      <= 8'd27;
      cfg_q.max_frame_bytes <= 13'd4096;
      cfg_q.big_endian      <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SYNC_FIRST:  cfg_q.sync_first      <= pwdata[7:0];
        REG_SYNC_SECOND: cfg_q.sync_second     <= pwdata[7:0];
        REG_START_CHAR:  cfg_q.start_char      <= pwdata[7:0];
        REG_END_FIRST:   cfg_q.end_first       <= pwdata[7:0];
        REG_END_SECOND:  cfg_q.end_second      <= pwdata[7:0];
        REG_ABORT_CHAR:  cfg_q.abort_char      <= pwdata[7:0];
        REG_MAX_BYTES:   cfg_q.max_frame_bytes <= pwdata[12:0];
        REG_BIG_ENDIAN:  cfg_q.big_endian      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC_FIRST:  prdata = {24'h0, cfg_q.sync_first};
      REG_SYNC_SECOND: prdata = {24'h0, cfg_q.sync_second};
      REG_START_CHAR:  prdata = {24'h0, cfg_q.start_char};
      REG_END_FIRST:   prdata = {24'h0, cfg_q.end_first};
      REG_END_SECOND:  prdata = {24'h0, cfg_q.end_second};
      REG_ABORT_CHAR:  prdata = {24'h0, cfg_q.abort_char};
      REG_MAX_BYTES:   prdata = {19'h0, cfg_q.max_frame_bytes};
      REG_BIG_ENDIAN:  prdata = {31'h0, cfg_q.big_endian};
      default:         prdata = 32'h0;
    endcase
  end

endmodule

// ----- rtl/gbad_frame_tracker.sv -----
// frame tracking state and per-word status logic
module gbad_frame_tracker #(
  parameter int unsigned BUFFER_BYTES = gbad_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  gbad_pkg::cfg_t    cfg_i,
  output gbad_pkg::result_t res_o
);
  import gbad_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

  frame_t        fr_q, fr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   idx_q;
  logic [31:0]   cap;
  logic [31:0]   max_ext;

  always_comb begin
    max_ext = 32'(cfg_i.max_frame_bytes);
    if (max_ext < 32'(MIN_CAP)) begin
      cap = 32'(MIN_CAP);
    end else if (max_ext > 32'(BUFFER_BYTES)) begin
      cap = 32'(BUFFER_BYTES);
    end else begin
      cap = max_ext;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [7:0] a_nx;
    logic       ok;
    b    = rx_byte_i;
    fr_d = fr_q;
    cnt_d = cnt_q;
    ok   = 1'b0;
    a_nx = fr_q.sum_a + b;
    res_o.byte_echo      = b;
    res_o.status         = ST_IGNORED;
    res_o.kind           = KIND_NONE;
    res_o.drop           = 1'b0;
    res_o.message_id     = 8'h00;
    res_o.payload_length = 16'h0000;
    res_o.stream_index   = idx_q;

    // pending frame already at the byte cap (limit clamped to MIN_CAP..BUFFER_BYTES)
    if (fr_d.mode != MODE_IDLE && 32'(cnt_d) >= cap) begin
      fr_d       = FRAME_CLEAR;
      cnt_d      = '0;
      res_o.drop = 1'b1;
    end

    unique case (fr_d.mode)
      MODE_IDLE: begin
        if (b == cfg_i.sync_first) begin
          fr_d         = FRAME_CLEAR;
          fr_d.mode    = MODE_BIN;
          cnt_d        = CW'(1);
          res_o.status = ST_IN_FRAME;
          res_o.kind   = KIND_BINARY;
        end else if (b == cfg_i.start_char) begin
          fr_d         = FRAME_CLEAR;
          fr_d.mode    = MODE_TXT;
          cnt_d        = CW'(1);
          res_o.status = ST_IN_FRAME;
          res_o.kind   = KIND_ASCII;
        end
      end
      MODE_BIN: begin
        cnt_d        = cnt_d + CW'(1);
        res_o.kind   = KIND_BINARY;
        res_o.status = ST_IN_FRAME;
        case (fr_d.phase)
          PH_SYNC2: begin
            if (b == cfg_i.sync_second) begin
              fr_d.phase = PH_ID;
            end else begin
              res_o.status = ST_INVALID_END;
              fr_d         = FRAME_CLEAR;
              cnt_d        = '0;
            end
          end
          PH_ID: begin
            fr_d.held_id     = b;
            fr_d.sum_a       = a_nx;
            fr_d.sum_b       = fr_q.sum_b + a_nx;
            fr_d.phase       = PH_LEN1;
            res_o.message_id = b;
          end
          PH_LEN1: begin
            fr_d.held_len    = {8'h00, b};
            fr_d.sum_a       = a_nx;
            fr_d.sum_b       = fr_q.sum_b + a_nx;
            fr_d.phase       = PH_LEN2;
            res_o.message_id = fr_d.held_id;
          end
          PH_LEN2: begin
            if (cfg_i.big_endian) begin
              fr_d.held_len = {fr_d.held_len[7:0], b};
            end else begin
              fr_d.held_len = {b, fr_d.held_len[7:0]};
            end
            fr_d.sum_a           = a_nx;
            fr_d.sum_b           = fr_q.sum_b + a_nx;
            fr_d.left            = {1'b0, fr_d.held_len} + 17'd2;
            fr_d.phase           = PH_BODY;
            res_o.message_id     = fr_d.held_id;
            res_o.payload_length = fr_d.held_len;
          end
          PH_BODY: begin
            res_o.message_id     = fr_d.held_id;
            res_o.payload_length = fr_d.held_len;
            if (fr_d.left > 17'd2) begin
              fr_d.sum_a = a_nx;
              fr_d.sum_b = fr_q.sum_b + a_nx;
            end else if (fr_d.left == 17'd2) begin
              fr_d.chk_ok = (b == fr_d.sum_a);
            end
            if (fr_d.left == 17'd1) begin
              // '$' as first sync skips the check bytes: only the length decides
              ok = (cnt_d > CW'(MIN_VALID_BYTES)) &&
                   ((cfg_i.sync_first == ASCII_MARK) ||
                    (fr_d.chk_ok && (b == fr_d.sum_b)));
              res_o.status = ok ? ST_VALID_END : ST_INVALID_END;
              fr_d         = FRAME_CLEAR;
              cnt_d        = '0;
            end else if (fr_d.left != 17'd0) begin
              fr_d.left = fr_d.left - 17'd1;
            end else begin
              res_o.status = ST_INVALID_END;
              fr_d         = FRAME_CLEAR;
              cnt_d        = '0;
            end
          end
          default: begin
            fr_d  = FRAME_CLEAR;
            cnt_d = '0;
          end
        endcase
      end
      MODE_TXT: begin
        cnt_d        = cnt_d + CW'(1);
        res_o.kind   = KIND_ASCII;
        res_o.status = ST_IN_FRAME;
        if (b == cfg_i.abort_char) begin
          res_o.status = ST_ABORTED;
          fr_d         = FRAME_CLEAR;
          cnt_d        = '0;
        end else if (b == cfg_i.end_first) begin
          fr_d.cr_seen = 1'b1;
        end else if (fr_d.cr_seen) begin
          if (b == cfg_i.end_second && cfg_i.start_char == ASCII_MARK &&
              cnt_d > CW'(MIN_VALID_BYTES)) begin
            res_o.status = ST_VALID_END;
          end else begin
            res_o.status = ST_INVALID_END;
          end
          fr_d  = FRAME_CLEAR;
          cnt_d = '0;
        end
      end
      default: begin
        fr_d  = FRAME_CLEAR;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q  <= FRAME_CLEAR;
      cnt_q <= '0;
      idx_q <= 32'h0;
    end else if (step_i) begin
      fr_q  <= fr_d;
      cnt_q <= cnt_d;
      idx_q <= idx_q + 32'd1;
    end
  end

endmodule

// ----- rtl/gbad_checker.sv -----
// port-level checks of the deframer, bound to the top level
module gbad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser
);
  import gbad_pkg::*;

  logic [31:0] exp_idx_q;
  logic        out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= 32'h0;
    end else if (out_acc) begin
      exp_idx_q <= exp_idx_q + 32'd1;
    end
  end

  // every word gets exactly one output word, numbered in order
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> m_axis_tdata[63:32] == exp_idx_q)
    else $error("stream index out of sequence");

  // ignored words carry no frame kind and framed words always do
  a_kind_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser[2:0] == ST_IGNORED) ==
                       (m_axis_tuser[4:3] == KIND_NONE)))
    else $error("frame kind and status disagree");

  // id and length fields only show up inside binary frames
  a_bin_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4:3] != KIND_BINARY) |->
      (m_axis_tdata[31:8] == 24'h0))
    else $error("binary header fields outside a binary frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output word changed");

endmodule

bind gnss_binary_ascii_deframer gbad_checker u_checker (.*);

// ----- dv/tb_gnss_binary_ascii_deframer.sv -----
// self-checking testbench of the gnss binary/ascii deframer: byte stream in, echoed status out
`timescale 1ns / 100ps

module tb_gnss_binary_ascii_deframer;
  import gbad_pkg::*;

  localparam int unsigned BUF_BYTES  = BUFFER_BYTES_DEF;
  localparam int unsigned LONG_STALL = 400;

  localparam cfg_t CFG_DEFAULT = '{
    sync_first:      8'd69,
    sync_second:     8'd82,
    start_char:      8'd36,
    end_first:       8'd13,
    end_second:      8'd10,
    abort_char:      8'd27,
    max_frame_bytes: 13'd4096,
    big_endian:      1'b0
  };

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_SUM_A,
    FLAW_BAD_SUM_B,
    FLAW_BAD_SYNC,
    FLAW_HEADER_ONLY,
    FLAW_ABORT,
    FLAW_BROKEN_END,
    FLAW_DOUBLE_CR
  } flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // byte_echo, message_id, payload_length, stream_index
  logic [7:0]  m_axis_tuser;           // frame_status, frame_kind, overflow_drop, zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gnss_binary_ascii_deframer uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // stimulus and expectation stores
  logic [7:0]  rx_bytes_q[$];
  result_t     echo_q[$];
  int unsigned bytes_queued = 0;
  bit          word_in_flight = 1'b0;
  int          fail_count = 0;

  // idling control
  bit          quiet = 1'b0;
  bit          long_stall_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned stall_left = 0;

  // deframer mirror: configuration and tracker state
  cfg_t        dut_cfg;
  mode_e       trk_mode;
  phase_e      trk_phase;
  logic        trk_cr;
  logic [7:0]  trk_id;
  logic [15:0] trk_len;
  int unsigned trk_left;
  int unsigned trk_count;
  logic [7:0]  trk_sum_a;
  logic [7:0]  trk_sum_b;
  logic        trk_chk_ok;
  logic [31:0] rx_count;

  result_t     drv_echo;
  result_t     mon_got;
  result_t     mon_want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("tb_gnss_binary_ascii_deframer NOT OK");
    $finish;
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_tracker();
    trk_mode   = MODE_IDLE;
    trk_phase  = PH_SYNC2;
    trk_cr     = 1'b0;
    trk_id     = 8'h00;
    trk_len    = 16'h0000;
    trk_left   = 0;
    trk_count  = 0;
    trk_sum_a  = 8'h00;
    trk_sum_b  = 8'h00;
    trk_chk_ok = 1'b0;
  endtask

  task automatic fletcher_add(input logic [7:0] b);
    trk_sum_a = trk_sum_a + b;
    trk_sum_b = trk_sum_b + trk_sum_a;
  endtask

  // advances the mirror by one received byte and gives the echo word it causes
  task automatic deframe_byte(input logic [7:0] b, output result_t r);
    int unsigned cap;
    logic        ok;
    r = '0;
    r.byte_echo = b;
    r.status = ST_IGNORED;
    r.kind = KIND_NONE;
    r.stream_index = rx_count;
    rx_count = rx_count + 32'd1;
    cap = 32'(dut_cfg.max_frame_bytes);
    if (cap < MIN_CAP) cap = MIN_CAP;
    if (cap > BUF_BYTES) cap = BUF_BYTES;
    if (trk_mode != MODE_IDLE && trk_count >= cap) begin
      clear_tracker();
      r.drop = 1'b1;
    end
    if (trk_mode == MODE_IDLE) begin
      if (b == dut_cfg.sync_first) begin
        clear_tracker();
        trk_mode = MODE_BIN;
        trk_count = 1;
        r.status = ST_IN_FRAME;
        r.kind = KIND_BINARY;
      end else if (b == dut_cfg.start_char) begin
        clear_tracker();
        trk_mode = MODE_TXT;
        trk_count = 1;
        r.status = ST_IN_FRAME;
        r.kind = KIND_ASCII;
      end
    end else if (trk_mode == MODE_BIN) begin
      trk_count++;
      r.kind = KIND_BINARY;
      r.status = ST_IN_FRAME;
      case (trk_phase)
        PH_SYNC2: begin
          // a wrong second sync byte is not taken as a new start
          if (b == dut_cfg.sync_second) trk_phase = PH_ID;
          else begin
            r.status = ST_INVALID_END;
            clear_tracker();
          end
        end
        PH_ID: begin
          trk_id = b;
          fletcher_add(b);
          trk_phase = PH_LEN1;
          r.message_id = trk_id;
        end
        PH_LEN1: begin
          trk_len = {8'h00, b};
          fletcher_add(b);
          trk_phase = PH_LEN2;
          r.message_id = trk_id;
        end
        PH_LEN2: begin
          if (dut_cfg.big_endian) trk_len = {trk_len[7:0], b};
          else trk_len = {b, trk_len[7:0]};
          fletcher_add(b);
          trk_left = trk_len + 2;
          trk_phase = PH_BODY;
          r.message_id = trk_id;
          r.payload_length = trk_len;
        end
        default: begin
          r.message_id = trk_id;
          r.payload_length = trk_len;
          if (trk_left > 2) fletcher_add(b);
          else if (trk_left == 2) trk_chk_ok = (b == trk_sum_a);
          if (trk_left == 1) begin
            ok = trk_count > MIN_VALID_BYTES;
            // with a dollar sync only the length decides
            if (dut_cfg.sync_first != ASCII_MARK) ok = ok && trk_chk_ok && (b == trk_sum_b);
            r.status = ok ? ST_VALID_END : ST_INVALID_END;
            clear_tracker();
          end else if (trk_left > 0) begin
            trk_left--;
          end else begin
            r.status = ST_INVALID_END;
            clear_tracker();
          end
        end
      endcase
    end else begin
      trk_count++;
      r.kind = KIND_ASCII;
      r.status = ST_IN_FRAME;
      // abort wins over the terminators, a repeated first terminator keeps the frame open
      if (b == dut_cfg.abort_char) begin
        r.status = ST_ABORTED;
        clear_tracker();
      end else if (b == dut_cfg.end_first) begin
        trk_cr = 1'b1;
      end else if (trk_cr) begin
        if (b == dut_cfg.end_second && dut_cfg.start_char == ASCII_MARK &&
            trk_count > MIN_VALID_BYTES)
          r.status = ST_VALID_END;
        else
          r.status = ST_INVALID_END;
        clear_tracker();
      end
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata, drv_echo);
        echo_q.insert(echo_q.size(), drv_echo);
        word_in_flight = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          s_axis_tdata <= rx_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          word_in_flight = 1'b1;
          send_gap = draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with its own long hold-off counter
  always @(posedge clk_i) begin
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = draw_gap();
    end
  end

  // checker of output words
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.byte_echo      = m_axis_tdata[7:0];
      mon_got.message_id     = m_axis_tdata[15:8];
      mon_got.payload_length = m_axis_tdata[31:16];
      mon_got.stream_index   = m_axis_tdata[63:32];
      mon_got.status         = status_e'(m_axis_tuser[2:0]);
      mon_got.kind           = kind_e'(m_axis_tuser[4:3]);
      mon_got.drop           = m_axis_tuser[5];
      if (echo_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: echo %h index %0d", mon_got.byte_echo,
                   mon_got.stream_index);
      end else begin
        mon_want = echo_q.pop_front();
        if (mon_got.byte_echo !== mon_want.byte_echo || mon_got.status !== mon_want.status ||
            mon_got.kind !== mon_want.kind || mon_got.drop !== mon_want.drop ||
            mon_got.message_id !== mon_want.message_id ||
            mon_got.payload_length !== mon_want.payload_length ||
            mon_got.stream_index !== mon_want.stream_index) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected echo %h status %0d kind %0d drop %b id %h len %h idx %0d",
                     mon_want.byte_echo, mon_want.status, mon_want.kind, mon_want.drop,
                     mon_want.message_id, mon_want.payload_length, mon_want.stream_index);
            $display("          got      echo %h status %0d kind %0d drop %b id %h len %h idx %0d",
                     mon_got.byte_echo, mon_got.status, mon_got.kind, mon_got.drop,
                     mon_got.message_id, mon_got.payload_length, mon_got.stream_index);
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper bits of each word carry junk, the register keeps only its own width
  task automatic set_config(input cfg_t c);
    apb_write(REG_SYNC_FIRST,  {24'($urandom), c.sync_first});
    apb_write(REG_SYNC_SECOND, {24'($urandom), c.sync_second});
    apb_write(REG_START_CHAR,  {24'($urandom), c.start_char});
    apb_write(REG_END_FIRST,   {24'($urandom), c.end_first});
    apb_write(REG_END_SECOND,  {24'($urandom), c.end_second});
    apb_write(REG_ABORT_CHAR,  {24'($urandom), c.abort_char});
    apb_write(REG_MAX_BYTES,   {19'($urandom), c.max_frame_bytes});
    apb_write(REG_BIG_ENDIAN,  {31'($urandom), c.big_endian});
    @(posedge clk_i);
    dut_cfg = c;
  endtask

  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || word_in_flight || echo_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_q.insert(rx_bytes_q.size(), b);
    bytes_queued++;
  endtask

  task automatic push_bin_frame(input logic [15:0] len, input flaw_e flaw);
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] body[$];
    ca = 8'h00;
    cb = 8'h00;
    queue_byte(dut_cfg.sync_first);
    if (flaw == FLAW_BAD_SYNC) begin
      queue_byte(dut_cfg.sync_second ^ 8'($urandom_range(1, 255)));
    end else begin
      queue_byte(dut_cfg.sync_second);
      body.insert(body.size(), 8'($urandom));
      if (dut_cfg.big_endian) begin
        body.insert(body.size(), len[15:8]);
        body.insert(body.size(), len[7:0]);
      end else begin
        body.insert(body.size(), len[7:0]);
        body.insert(body.size(), len[15:8]);
      end
      if (flaw != FLAW_HEADER_ONLY)
        for (int i = 0; i < len; i++) body.insert(body.size(), 8'($urandom));
      foreach (body[i]) begin
        ca += body[i];
        cb += ca;
        queue_byte(body[i]);
      end
      if (flaw != FLAW_HEADER_ONLY) begin
        queue_byte(flaw == FLAW_BAD_SUM_A ? ca ^ 8'($urandom_range(1, 255)) : ca);
        queue_byte(flaw == FLAW_BAD_SUM_B ? cb ^ 8'($urandom_range(1, 255)) : cb);
      end
    end
  endtask

  task automatic push_txt_frame(input int unsigned n, input flaw_e flaw);
    logic [7:0] v;
    queue_byte(dut_cfg.start_char);
    repeat (n) begin
      do v = 8'($urandom); while (v == dut_cfg.abort_char || v == dut_cfg.end_first);
      queue_byte(v);
    end
    if (flaw == FLAW_ABORT) begin
      queue_byte(dut_cfg.abort_char);
    end else begin
      queue_byte(dut_cfg.end_first);
      if (flaw == FLAW_DOUBLE_CR) queue_byte(dut_cfg.end_first);
      if (flaw == FLAW_BROKEN_END) begin
        do v = 8'($urandom);
        while (v == dut_cfg.end_second || v == dut_cfg.end_first || v == dut_cfg.abort_char);
        queue_byte(v);
      end else begin
        queue_byte(dut_cfg.end_second);
      end
    end
  endtask

  // mostly well-formed frames with random content, some broken ones and line noise
  task automatic push_traffic(input int unsigned n, input bit long_ok);
    int unsigned target;
    int unsigned r;
    flaw_e       f;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        case ($urandom_range(0, 19))
          0: f = FLAW_BAD_SUM_A;
          1: f = FLAW_BAD_SUM_B;
          2: f = FLAW_BAD_SYNC;
          3: f = long_ok ? FLAW_HEADER_ONLY : FLAW_NONE;
          default: f = FLAW_NONE;
        endcase
        if (f == FLAW_HEADER_ONLY) push_bin_frame(16'($urandom), f);
        else if ($urandom_range(0, 9) == 0) push_bin_frame(16'($urandom_range(13, 40)), f);
        else push_bin_frame(16'($urandom_range(0, 12)), f);
      end else if (r < 75) begin
        case ($urandom_range(0, 9))
          0: f = FLAW_ABORT;
          1: f = FLAW_BROKEN_END;
          2: f = FLAW_DOUBLE_CR;
          default: f = FLAW_NONE;
        endcase
        push_txt_frame($urandom_range(0, 14), f);
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t c;
    dut_cfg = CFG_DEFAULT;
    clear_tracker();
    rx_count = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults, short directed run first
    set_config(CFG_DEFAULT);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_bin_frame(16'd2, FLAW_NONE);
    queue_byte(dut_cfg.sync_first);
    queue_byte(dut_cfg.sync_first);
    push_txt_frame(5, FLAW_DOUBLE_CR);
    push_txt_frame(1, FLAW_ABORT);
    push_txt_frame(0, FLAW_BROKEN_END);
    push_bin_frame(16'd120, FLAW_NONE);
    push_traffic(150, 1'b0);
    // output held off while the input keeps offering words
    long_stall_req = 1'b1;
    push_traffic(300, 1'b0);
    wait_drained();
    quiet = 1'b1;
    push_traffic(100, 1'b0);
    wait_drained();
    quiet = 1'b0;

    // all-zero and all-one extremes, big endian length, smallest frame limit
    c = '{sync_first: 8'h00, sync_second: 8'hFF, start_char: ASCII_MARK, end_first: 8'hFF,
          end_second: 8'h00, abort_char: 8'h80, max_frame_bytes: 13'd0, big_endian: 1'b1};
    set_config(c);
    push_bin_frame(16'hFFFF, FLAW_HEADER_ONLY);
    push_bin_frame(16'd2, FLAW_NONE);
    push_traffic(150, 1'b1);
    wait_drained();

    // dollar sync: binary frames judged on length only, ascii frames never valid
    c = '{sync_first: ASCII_MARK, sync_second: 8'h42, start_char: 8'h3A, end_first: 8'd13,
          end_second: 8'd10, abort_char: 8'd27, max_frame_bytes: 13'd9, big_endian: 1'b0};
    set_config(c);
    push_bin_frame(16'hFFFF, FLAW_HEADER_ONLY);
    push_traffic(150, 1'b1);
    wait_drained();

    // limit above the buffer size, big endian lengths
    c = CFG_DEFAULT;
    c.max_frame_bytes = 13'h1FFF;
    c.big_endian = 1'b1;
    set_config(c);
    quiet = 1'b1;
    push_traffic(80, 1'b0);
    wait_drained();
    quiet = 1'b0;

    for (int k = 0; k < 3; k++) begin
      c.sync_first      = 8'($urandom);
      c.sync_second     = 8'($urandom);
      c.start_char      = $urandom_range(0, 1) ? ASCII_MARK : 8'($urandom);
      c.end_first       = 8'($urandom);
      c.end_second      = 8'($urandom);
      c.abort_char      = 8'($urandom);
      c.max_frame_bytes = ($urandom_range(0, 3) == 0) ? 13'($urandom)
                                                      : 13'($urandom_range(9, 64));
      c.big_endian      = 1'($urandom_range(0, 1));
      set_config(c);
      push_traffic(80, c.max_frame_bytes <= 64);
      wait_drained();
    end

    wait_drained();
    if (fail_count == 0 && echo_q.size() == 0) begin
      $display("tb_gnss_binary_ascii_deframer OK");
    end else begin
      $display("tb_gnss_binary_ascii_deframer NOT OK");
    end
    $finish;
  end

endmodule
